// ----- sv/ptt_pkg.sv -----
// Shared types for the position translation table: operation and status codes,
// and the search token and insert broadcast that pass between the top level and the cells.
// No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int unsigned LsnW = 64;

  typedef enum logic [1:0] {
    FUNC_INSERT    = 2'd0,
    FUNC_EXACT_FWD = 2'd1,
    FUNC_FLOOR_FWD = 2'd2,
    FUNC_EXACT_REV = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // A lookup travelling down the row of cells together with its best match so far.
  typedef struct packed {
    logic            vld;
    func_e           func;
    logic [LsnW-1:0] key_up;
    logic [LsnW-1:0] key_down;
    logic            found;
    logic [LsnW-1:0] match_up;
    logic [LsnW-1:0] match_down;
  } tok_t;

  // Insert broadcast to every cell; only the cell at the fill position takes it.
  typedef struct packed {
    logic            vld;
    logic [LsnW-1:0] up;
    logic [LsnW-1:0] down;
  } ins_t;

endpackage

`default_nettype wire

// ----- sv/ptt_cell.sv -----
// One cell of the table: holds a single position pair and updates the passing lookup token.
// Depends on ptt_pkg for the token and insert types.
`default_nettype none

module ptt_cell #(
  parameter int unsigned CntW = 9,
  parameter int unsigned Idx  = 0
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               adv_i,
  input  wire  [CntW-1:0]   count_i,
  input  ptt_pkg::ins_t     ins_i,
  input  ptt_pkg::tok_t     tok_i,
  output ptt_pkg::tok_t     tok_o
);

  logic [ptt_pkg::LsnW-1:0] up_q;
  logic [ptt_pkg::LsnW-1:0] down_q;
  logic                     wr_en;
  logic                     occupied;
  ptt_pkg::tok_t            tok_d;
  ptt_pkg::tok_t            tok_q;

  assign wr_en    = ins_i.vld && (count_i == CntW'(Idx));
  assign occupied = CntW'(Idx) < count_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      up_q   <= ins_i.up;
      down_q <= ins_i.down;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && occupied) begin
      case (tok_i.func)
        ptt_pkg::FUNC_EXACT_FWD: begin
          if (!tok_i.found && (up_q == tok_i.key_up)) begin
            tok_d.found      = 1'b1;
            tok_d.match_up   = up_q;
            tok_d.match_down = down_q;
          end
        end
        ptt_pkg::FUNC_EXACT_REV: begin
          if (!tok_i.found && (down_q == tok_i.key_down)) begin
            tok_d.found      = 1'b1;
            tok_d.match_up   = up_q;
            tok_d.match_down = down_q;
          end
        end
        ptt_pkg::FUNC_FLOOR_FWD: begin
          // A strictly greater upstream is needed to displace, so the earliest entry wins ties.
          if ((up_q <= tok_i.key_up) && (!tok_i.found || (up_q > tok_i.match_up))) begin
            tok_d.found      = 1'b1;
            tok_d.match_up   = up_q;
            tok_d.match_down = down_q;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ----- sv/position_translation_table_unit.sv -----
// Position translation table: an insert's result is valid the cycle after the transfer.
// A lookup walks a row of TABLE_DEPTH cells, one cell per cycle while the row is not held, through
// each cell's token register and then the output register; one item is in progress at a time.
// A new item is taken as soon as the previous lookup has left the row and the output register is free.
// Reset clears the entry count, the row's tokens and the output valid flag; stored pairs are not cleared.
// Depends on ptt_pkg and ptt_cell.
`default_nettype none

module position_translation_table_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [127:0] s_axis_tdata_i,  // [63:0] upstream_lsn, [127:64] downstream_lsn
  input  wire  [1:0]   s_axis_tuser_i,  // [1:0] func
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [143:0] m_axis_tdata_o,  // [63:0] found_upstream, [127:64] found_downstream,
                                        // [136:128] entries_held, [143:137] zero
  output logic [1:0]   m_axis_tuser_o   // [1:0] status
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LsnW = ptt_pkg::LsnW;

  ptt_pkg::tok_t         tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] tok_vld;
  ptt_pkg::ins_t         ins;
  ptt_pkg::func_e        in_func;
  ptt_pkg::tok_t         tok_last;

  logic [CntW-1:0] count_q, count_d;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [LsnW-1:0] out_up_q, out_up_d;
  logic [LsnW-1:0] out_down_q, out_down_d;
  logic [8:0]      out_held_q, out_held_d;

  logic s_acc;
  logic out_free;
  logic adv;
  logic is_insert;
  logic full;
  logic chain_done;

  assign in_func   = ptt_pkg::func_e'(s_axis_tuser_i[1:0]);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !busy_q && out_free;
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign is_insert = (in_func == ptt_pkg::FUNC_INSERT);
  assign full      = (count_q == CntW'(TABLE_DEPTH));

  assign tok_last   = tok[TABLE_DEPTH];
  // The row holds still only while a finished lookup waits for the output register.
  assign adv        = !(tok_last.vld && !out_free);
  assign chain_done = tok_last.vld && out_free;

  assign ins.vld  = s_acc && is_insert && !full;
  assign ins.up   = s_axis_tdata_i[63:0];
  assign ins.down = s_axis_tdata_i[127:64];

  always_comb begin
    tok[0].vld        = s_acc && !is_insert;
    tok[0].func       = in_func;
    tok[0].key_up     = s_axis_tdata_i[63:0];
    tok[0].key_down   = s_axis_tdata_i[127:64];
    tok[0].found      = 1'b0;
    tok[0].match_up   = '0;
    tok[0].match_down = '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ptt_cell #(
      .CntW (CntW),
      .Idx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .count_i (count_q),
      .ins_i   (ins),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].vld;
  end

  always_comb begin
    count_d      = count_q;
    busy_d       = busy_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_up_d     = out_up_q;
    out_down_d   = out_down_q;
    out_held_d   = out_held_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (s_acc && is_insert) begin
      out_valid_d = 1'b1;
      out_up_d    = '0;
      out_down_d  = '0;
      if (full) begin
        out_status_d = 2'(ptt_pkg::ST_FULL);
        out_held_d   = 9'(count_q);
      end else begin
        count_d      = count_q + CntW'(1);
        out_status_d = 2'(ptt_pkg::ST_OK);
        out_held_d   = 9'(count_q + CntW'(1));
      end
    end else if (s_acc) begin
      busy_d = 1'b1;
    end

    if (chain_done) begin
      busy_d       = 1'b0;
      out_valid_d  = 1'b1;
      out_status_d = tok_last.found ? 2'(ptt_pkg::ST_OK) : 2'(ptt_pkg::ST_NOT_FOUND);
      out_up_d     = tok_last.match_up;
      out_down_d   = tok_last.match_down;
      out_held_d   = 9'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_up_q     <= out_up_d;
    out_down_q   <= out_down_d;
    out_held_q   <= out_held_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {7'd0, out_held_q, out_down_q, out_up_q};

  // At most one lookup is ever in the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one lookup in the cell row");

  // A lookup in the row always belongs to an item that is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.vld |-> busy_q)
    else $error("lookup leaves the row while the unit is not busy");

  // The entry count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // An insert into a table with room grows the count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && is_insert && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not advance the entry count");

  // A finished lookup lands in the output register and frees the unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_done |=> (out_valid_q && !busy_q))
    else $error("finished lookup not delivered to the output register");

endmodule

`default_nettype wire

// ----- tb/tb_position_translation_table_unit.sv -----
// Self-checking testbench for position_translation_table_unit: inserts and the three lookups
// are streamed in with random gaps and stalls, and each answer is checked against a local table.
// Depends on ptt_pkg and the RTL of the unit.
`default_nettype none

module tb_position_translation_table_unit;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    ptt_pkg::func_e func;
    logic [63:0]    up;
    logic [63:0]    dn;
    bit             drain;  // hold this transfer back until every answer has arrived
  } request_t;

  typedef struct {
    ptt_pkg::status_e status;
    logic [63:0]      up;
    logic [63:0]      dn;
    logic [8:0]       held;
  } answer_t;

  logic         clk_i   = 1'b0;
  logic         rst_ni  = 1'b0;
  logic         s_valid = 1'b0;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_ready = 1'b0;
  wire          s_axis_tready_o;
  wire          m_axis_tvalid_o;
  wire  [143:0] m_axis_tdata_o;
  wire  [1:0]   m_axis_tuser_o;

  request_t    request_q[$];
  answer_t     answer_q[$];
  logic [63:0] gen_up[$];
  logic [63:0] gen_dn[$];
  logic [63:0] pair_up[DEPTH];
  logic [63:0] pair_dn[DEPTH];
  int          pairs_held = 0;
  int          errors     = 0;
  int          awaiting   = 0;
  int          gap_left   = 0;
  int          stall_left = 0;
  int          in_calm    = 0;
  int          out_calm   = 0;
  int          cycles     = 0;
  request_t    nxt;

  position_translation_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Mostly random waits, with the odd stretch of back-to-back transfers.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Applies one request to the local table and returns the answer the unit must give.
  function automatic answer_t translate_position(ptt_pkg::func_e func, logic [63:0] kup,
                                                 logic [63:0] kdn);
    answer_t a;
    bit      hit;
    a.status = ptt_pkg::ST_NOT_FOUND;
    a.up     = '0;
    a.dn     = '0;
    hit      = 1'b0;
    if (func == ptt_pkg::FUNC_INSERT) begin
      if (pairs_held >= DEPTH) begin
        a.status = ptt_pkg::ST_FULL;
      end else begin
        pair_up[pairs_held] = kup;
        pair_dn[pairs_held] = kdn;
        pairs_held++;
        a.status = ptt_pkg::ST_OK;
      end
    end else begin
      for (int i = 0; i < pairs_held; i++) begin
        if (func == ptt_pkg::FUNC_EXACT_FWD && !hit && pair_up[i] == kup) begin
          hit = 1'b1;
          a.up = pair_up[i];
          a.dn = pair_dn[i];
        end else if (func == ptt_pkg::FUNC_EXACT_REV && !hit && pair_dn[i] == kdn) begin
          hit = 1'b1;
          a.up = pair_up[i];
          a.dn = pair_dn[i];
        end else if (func == ptt_pkg::FUNC_FLOOR_FWD && pair_up[i] <= kup &&
                     (!hit || pair_up[i] > a.up)) begin
          hit = 1'b1;
          a.up = pair_up[i];
          a.dn = pair_dn[i];
        end
      end
      if (hit) a.status = ptt_pkg::ST_OK;
    end
    a.held = 9'(pairs_held);
    return a;
  endfunction

  // The generator keeps its own list of stored pairs so that keys can be aimed at real entries.
  task automatic add_request(ptt_pkg::func_e func, logic [63:0] up, logic [63:0] dn,
                             bit drain = 1'b0);
    request_t r;
    r.func  = func;
    r.up    = up;
    r.dn    = dn;
    r.drain = drain;
    request_q.push_back(r);
    if (func == ptt_pkg::FUNC_INSERT && gen_up.size() < DEPTH) begin
      gen_up.push_back(up);
      gen_dn.push_back(dn);
    end
  endtask

  function automatic logic [63:0] pick_position(bit upstream_side);
    logic [63:0] v;
    int          n;
    int          idx;
    n = gen_up.size();
    idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        if (n > 0) v = upstream_side ? gen_up[idx] : gen_dn[idx];
      end
      3: begin
        if (n > 0) v = (upstream_side ? gen_up[idx] : gen_dn[idx]) +
                       64'($urandom_range(0, 2)) - 64'd1;
      end
      4: v = 64'($urandom_range(0, 15));
      5: v = ALL_ONES - 64'($urandom_range(0, 15));
      default: ;
    endcase
    return v;
  endfunction

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Driver: presents queued requests, holding each until its transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      gap_left = 0;
    end else begin
      if (s_valid && s_axis_tready_o) gap_left = draw_wait(in_calm);
      if (!(s_valid && !s_axis_tready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain && (awaiting != 0 || s_valid))) begin
          nxt = request_q.pop_front();
          s_valid <= 1'b1;
          s_tdata <= {nxt.dn, nxt.up};
          s_tuser <= nxt.func;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on each accepted request and checks each answer against the oldest one.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      awaiting   <= 0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected answer, expected none, actual %h status %h",
                   $time, m_axis_tdata_o, m_axis_tuser_o);
          errors++;
        end else begin
          want = answer_q.pop_front();
          check_field("status", 64'(want.status), 64'(m_axis_tuser_o));
          check_field("found_upstream", want.up, m_axis_tdata_o[63:0]);
          check_field("found_downstream", want.dn, m_axis_tdata_o[127:64]);
          check_field("entries_held", 64'(want.held), 64'(m_axis_tdata_o[136:128]));
          check_field("padding", '0, 64'(m_axis_tdata_o[143:137]));
        end
        stall_left = draw_wait(out_calm);
      end
      if (s_valid && s_axis_tready_o)
        answer_q.push_back(translate_position(ptt_pkg::func_e'(s_tuser), s_tdata[63:0],
                                              s_tdata[127:64]));
      awaiting <= answer_q.size();
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    ptt_pkg::func_e func;
    // Lookups on an empty table find nothing.
    add_request(ptt_pkg::FUNC_EXACT_FWD, '0, '0);
    add_request(ptt_pkg::FUNC_FLOOR_FWD, ALL_ONES, '0);
    add_request(ptt_pkg::FUNC_EXACT_REV, '0, '0);
    // Extreme positions, then pairs sharing an upstream or a downstream.
    add_request(ptt_pkg::FUNC_INSERT, '0, ALL_ONES);
    add_request(ptt_pkg::FUNC_INSERT, ALL_ONES, '0);
    add_request(ptt_pkg::FUNC_INSERT, 64'd100, 64'd200);
    add_request(ptt_pkg::FUNC_INSERT, 64'd100, 64'd300);
    add_request(ptt_pkg::FUNC_INSERT, 64'd50, 64'd200);
    add_request(ptt_pkg::FUNC_EXACT_FWD, 64'd100, '0);
    add_request(ptt_pkg::FUNC_EXACT_REV, '0, 64'd200);
    add_request(ptt_pkg::FUNC_EXACT_FWD, ALL_ONES, '0);
    add_request(ptt_pkg::FUNC_EXACT_REV, '0, ALL_ONES);
    add_request(ptt_pkg::FUNC_EXACT_FWD, 64'd7, '0);
    add_request(ptt_pkg::FUNC_EXACT_REV, '0, 64'd12345);
    add_request(ptt_pkg::FUNC_FLOOR_FWD, 64'd99, '0);
    add_request(ptt_pkg::FUNC_FLOOR_FWD, 64'd100, '0);
    add_request(ptt_pkg::FUNC_FLOOR_FWD, '0, '0);
    add_request(ptt_pkg::FUNC_FLOOR_FWD, ALL_ONES, ALL_ONES);
    add_request(ptt_pkg::FUNC_FLOOR_FWD, 64'd1000, '0);
    // Random traffic fills the table well before the end, so later inserts meet a full table.
    for (int k = 0; k < 830; k++) begin
      if ($urandom_range(0, 99) < ((gen_up.size() < DEPTH) ? 40 : 10))
        func = ptt_pkg::FUNC_INSERT;
      else
        func = ptt_pkg::func_e'($urandom_range(1, 3));
      add_request(func, pick_position(1'b1), pick_position(1'b0), k == 0 || k == 415);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (request_q.size() != 0 || s_valid || awaiting != 0);
    repeat (DEPTH + 20) @(posedge clk_i);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
